// ===== rtl/lpi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpi_pkg
// shared constants and types of the line pair intersection block
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned IN_W           = 16;
  localparam int unsigned OUT_W          = 48;
  localparam int unsigned CLAMP_W        = 64;
  localparam int unsigned HALF_W         = 32;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_VERTICAL = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

endpackage
`default_nettype wire

// ===== rtl/lpi_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpi_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lpi_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          v_q    [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] nq_q   [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift next dividend bit in, subtract when it fits
    assign trial = {rem_in, nq_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_q[k]   <= {nq_in[NW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule
`default_nettype wire

// ===== rtl/line_pair_intersection_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_pair_intersection_top
// crossing point of two lines given by endpoints, fully pipelined
// ----------------------------------------------------------------------------
// usage:
// - input channel (in_valid_i / in_ready_o) takes one item: two lines as
//   endpoint pairs plus a flag asking for a segment bounds check
// - output channel (out_valid_o / out_ready_i) returns one item per input:
//   status, and crossing x / y in fixed point with FRAC_BITS fraction bits,
//   saturated to 48 bits; any miss returns -1.0 for both
// - throughput: one item per cycle while the output is not stalled, items flow back to back
// - the path holds the gradient divider (COORD_BITS+FRAC_BITS stages) and the
//   crossing divider (2*COORD_BITS+2*FRAC_BITS+3 stages), one quotient bit
//   per stage
// - a stall on the output freezes the whole pipeline; the last stage is the
//   output register, so the input stays ready while that register is empty
//   or being drained
// - reset clears all stage valid bits; the pipeline then runs empty
// ----------------------------------------------------------------------------
module line_pair_intersection_top #(
  parameter int unsigned COORD_BITS = lpi_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = lpi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [lpi_pkg::IN_W-1:0]     a_x1_i,
  input  wire logic signed [lpi_pkg::IN_W-1:0]     a_y1_i,
  input  wire logic signed [lpi_pkg::IN_W-1:0]     a_x2_i,
  input  wire logic signed [lpi_pkg::IN_W-1:0]     a_y2_i,
  input  wire logic signed [lpi_pkg::IN_W-1:0]     b_x1_i,
  input  wire logic signed [lpi_pkg::IN_W-1:0]     b_y1_i,
  input  wire logic signed [lpi_pkg::IN_W-1:0]     b_x2_i,
  input  wire logic signed [lpi_pkg::IN_W-1:0]     b_y2_i,
  input  wire logic                                between_points_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output lpi_pkg::status_e                         status_o,
  output logic signed [lpi_pkg::OUT_W-1:0]         cross_x_o,
  output logic signed [lpi_pkg::OUT_W-1:0]         cross_y_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned MTW  = 8 * C + 1;         // coords plus segment flag
  localparam int unsigned GNW  = C + F;             // gradient quotient bits
  localparam int unsigned MW   = C + F + 1;         // signed gradient
  localparam int unsigned PW   = C + MW;            // x1 * gradient
  localparam int unsigned CW   = PW + 1;            // intercept
  localparam int unsigned NWD  = CW + 1 + F;        // crossing dividend
  localparam int unsigned XW   = NWD + 1;           // signed crossing x
  localparam int unsigned XE   = (XW > 64) ? XW : 65;
  localparam int unsigned LW   = MW + lpi_pkg::HALF_W + 1;
  localparam int unsigned HW   = MW + lpi_pkg::HALF_W;
  localparam int unsigned YP   = MW + lpi_pkg::CLAMP_W;
  localparam int unsigned YW   = YP + 1;
  localparam int unsigned CMPW = (XE > YW) ? XE : YW;
  localparam int unsigned OW   = lpi_pkg::OUT_W;
  localparam int unsigned SWA  = MTW + 2;
  localparam int unsigned SWX  = 3 + MW + CW + MTW;

  localparam logic signed [XE-1:0] X_HI =
    $signed({{(XE-63){1'b0}}, {63{1'b1}}});
  localparam logic signed [XE-1:0] X_LO =
    $signed({{(XE-63){1'b1}}, {63{1'b0}}});
  localparam logic signed [CMPW-1:0] S_HI =
    $signed({{(CMPW-47){1'b0}}, {47{1'b1}}});
  localparam logic signed [CMPW-1:0] S_LO =
    $signed({{(CMPW-47){1'b1}}, {47{1'b0}}});
  localparam logic [OW-1:0] MISS = ~((OW'(1) << F) - OW'(1));

  // coordinate k of a packed item: ax1 ay1 ax2 ay2 bx1 by1 bx2 by2
  function automatic logic signed [C-1:0] crd(input logic [MTW-1:0] m, input int k);
    crd = $signed(m[k*C +: C]);
  endfunction

  // limits included; bounds are min/max of the endpoints
  function automatic logic inside_f(input logic signed [CMPW-1:0] v,
                                    input logic signed [C-1:0] p,
                                    input logic signed [C-1:0] q);
    logic signed [CMPW-1:0] lo;
    logic signed [CMPW-1:0] hi;
    lo = (p < q) ? CMPW'(p) : CMPW'(q);
    hi = (p < q) ? CMPW'(q) : CMPW'(p);
    lo = lo <<< F;
    hi = hi <<< F;
    inside_f = (v >= lo) && (v <= hi);
  endfunction

  function automatic logic [OW-1:0] sat_f(input logic signed [CMPW-1:0] v);
    if (v > S_HI) begin
      sat_f = S_HI[OW-1:0];
    end else if (v < S_LO) begin
      sat_f = S_LO[OW-1:0];
    end else begin
      sat_f = v[OW-1:0];
    end
  endfunction

  // global advance: the whole pipe moves unless the output item is stalled
  logic en;
  logic out_between_q;

  // ---- stage 1: input capture, coordinates cut or zero-extended to C bits
  logic [lpi_pkg::IN_W-1:0] raw [8];
  logic [C-1:0]             cin [8];
  logic                     s1_v_q;
  logic [MTW-1:0]           s1_meta_q;

  assign raw[0] = a_x1_i;
  assign raw[1] = a_y1_i;
  assign raw[2] = a_x2_i;
  assign raw[3] = a_y2_i;
  assign raw[4] = b_x1_i;
  assign raw[5] = b_y1_i;
  assign raw[6] = b_x2_i;
  assign raw[7] = b_y2_i;

  for (genvar i = 0; i < 8; i++) begin : g_coord
    if (C <= lpi_pkg::IN_W) begin : g_narrow
      assign cin[i] = raw[i][C-1:0];
    end else begin : g_wide
      // wider coordinates see the field bits as a plain unsigned value
      assign cin[i] = {{(C-lpi_pkg::IN_W){1'b0}}, raw[i]};
    end
  end

  // ---- stage 2: deltas, vertical check, magnitudes for the gradient divide
  logic signed [C:0] dxa, dya, dxb, dyb;
  logic [C:0]        dxa_a, dya_a, dxb_a, dyb_a;
  logic              s2_v_q;
  logic [MTW-1:0]    s2_meta_q;
  logic              s2_vert_q, s2_nega_q, s2_negb_q;
  logic [C-1:0]      s2_dxa_q, s2_dya_q, s2_dxb_q, s2_dyb_q;

  assign dxa   = (C+1)'(crd(s1_meta_q, 2)) - (C+1)'(crd(s1_meta_q, 0));
  assign dya   = (C+1)'(crd(s1_meta_q, 3)) - (C+1)'(crd(s1_meta_q, 1));
  assign dxb   = (C+1)'(crd(s1_meta_q, 6)) - (C+1)'(crd(s1_meta_q, 4));
  assign dyb   = (C+1)'(crd(s1_meta_q, 7)) - (C+1)'(crd(s1_meta_q, 5));
  assign dxa_a = dxa[C] ? -dxa : dxa;
  assign dya_a = dya[C] ? -dya : dya;
  assign dxb_a = dxb[C] ? -dxb : dxb;
  assign dyb_a = dyb[C] ? -dyb : dyb;

  // ---- gradient dividers: |dy| * 2^F / |dx|
  logic             ga_v, gb_v;
  logic [GNW-1:0]   ga_q, gb_q;
  logic [SWA-1:0]   ga_side;
  logic             gb_side;

  lpi_div #(.NW(GNW), .DW(C), .SW(SWA)) u_div_ga (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .num_i   ({s2_dya_q, {F{1'b0}}}),
    .den_i   (s2_dxa_q),
    .side_i  ({s2_vert_q, s2_nega_q, s2_meta_q}),
    .valid_o (ga_v),
    .quo_o   (ga_q),
    .side_o  (ga_side)
  );

  lpi_div #(.NW(GNW), .DW(C), .SW(1)) u_div_gb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .num_i   ({s2_dyb_q, {F{1'b0}}}),
    .den_i   (s2_dxb_q),
    .side_i  (s2_negb_q),
    .valid_o (gb_v),
    .quo_o   (gb_q),
    .side_o  (gb_side)
  );

  // ---- stage 3: signed gradients
  logic signed [MW-1:0] ma_u, mb_u;
  logic                 s3_v_q, s3_vert_q;
  logic signed [MW-1:0] s3_ma_q, s3_mb_q;
  logic [MTW-1:0]       s3_meta_q;

  assign ma_u = $signed(MW'(ga_q));
  assign mb_u = $signed(MW'(gb_q));

  // ---- stage 4: x1 * m products, gradient difference, parallel check
  logic                 s4_v_q, s4_vert_q, s4_par_q;
  logic signed [PW-1:0] s4_pa_q, s4_pb_q;
  logic signed [MW-1:0] s4_ma_q;
  logic signed [MW:0]   s4_den_q;
  logic [MTW-1:0]       s4_meta_q;

  // ---- stage 5: intercepts
  logic                 s5_v_q, s5_vert_q, s5_par_q;
  logic signed [CW-1:0] s5_ca_q, s5_cb_q;
  logic signed [MW-1:0] s5_ma_q;
  logic signed [MW:0]   s5_den_q;
  logic [MTW-1:0]       s5_meta_q;

  // ---- stage 6: crossing dividend and divisor magnitudes
  logic signed [CW:0]    cdiff;
  logic signed [NWD-1:0] xnum;
  logic [NWD-1:0]        xnum_a;
  logic [MW:0]           xden_a;
  logic                  s6_v_q, s6_vert_q, s6_par_q, s6_negx_q;
  logic [NWD-1:0]        s6_num_q;
  logic [MW-1:0]         s6_den_q;
  logic signed [CW-1:0]  s6_ca_q;
  logic signed [MW-1:0]  s6_ma_q;
  logic [MTW-1:0]        s6_meta_q;

  assign cdiff  = (CW+1)'(s5_cb_q) - (CW+1)'(s5_ca_q);
  assign xnum   = NWD'(cdiff) <<< F;
  assign xnum_a = xnum[NWD-1] ? -xnum : xnum;
  assign xden_a = s5_den_q[MW] ? -s5_den_q : s5_den_q;

  // ---- crossing divider
  logic           xd_v;
  logic [NWD-1:0] xd_q;
  logic [SWX-1:0] xd_side;

  lpi_div #(.NW(NWD), .DW(MW), .SW(SWX)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_v_q),
    .num_i   (s6_num_q),
    .den_i   (s6_den_q),
    .side_i  ({s6_vert_q, s6_par_q, s6_negx_q, s6_ma_q, s6_ca_q, s6_meta_q}),
    .valid_o (xd_v),
    .quo_o   (xd_q),
    .side_o  (xd_side)
  );

  // ---- stage 7: signed crossing x
  logic signed [XE-1:0] x_u;
  logic                 s7_v_q, s7_vert_q, s7_par_q;
  logic signed [XE-1:0] s7_x_q;
  logic signed [MW-1:0] s7_ma_q;
  logic signed [CW-1:0] s7_ca_q;
  logic [MTW-1:0]       s7_meta_q;

  assign x_u = $signed(XE'(xd_q));

  // ---- stage 8: x clamped to 64 bits for the y product
  logic                 s8_v_q, s8_vert_q, s8_par_q;
  logic signed [XE-1:0] s8_x_q;
  logic [63:0]          s8_xc_q;
  logic signed [MW-1:0] s8_ma_q;
  logic signed [CW-1:0] s8_ca_q;
  logic [MTW-1:0]       s8_meta_q;

  // ---- stage 9: partial products of m * x
  logic                 s9_v_q, s9_vert_q, s9_par_q;
  logic signed [XE-1:0] s9_x_q;
  logic signed [LW-1:0] s9_plo_q;
  logic signed [HW-1:0] s9_phi_q;
  logic signed [CW-1:0] s9_ca_q;
  logic [MTW-1:0]       s9_meta_q;

  // ---- stage 10: partial product sum
  logic                 s10_v_q, s10_vert_q, s10_par_q;
  logic signed [XE-1:0] s10_x_q;
  logic signed [YP-1:0] s10_ps_q;
  logic signed [CW-1:0] s10_ca_q;
  logic [MTW-1:0]       s10_meta_q;

  // ---- stage 11: y = (m * x) >> F + c, floor shift
  logic                 s11_v_q, s11_vert_q, s11_par_q;
  logic signed [XE-1:0] s11_x_q;
  logic signed [YW-1:0] s11_y_q;
  logic [MTW-1:0]       s11_meta_q;

  // ---- stage 12: bounds check, status, saturation -> output register
  logic signed [CMPW-1:0] xf, yf;
  logic                   in_all;
  lpi_pkg::status_e       st_d;
  logic                   out_v_q;
  lpi_pkg::status_e       out_st_q;
  logic [OW-1:0]          out_x_q, out_y_q;

  assign xf     = CMPW'(s11_x_q);
  assign yf     = CMPW'(s11_y_q);
  assign in_all = inside_f(xf, crd(s11_meta_q, 0), crd(s11_meta_q, 2))
               && inside_f(yf, crd(s11_meta_q, 1), crd(s11_meta_q, 3))
               && inside_f(xf, crd(s11_meta_q, 4), crd(s11_meta_q, 6))
               && inside_f(yf, crd(s11_meta_q, 5), crd(s11_meta_q, 7));

  // vertical wins over parallel, both win over the segment check
  always_comb begin
    priority if (s11_vert_q) begin
      st_d = lpi_pkg::ST_VERTICAL;
    end else if (s11_par_q) begin
      st_d = lpi_pkg::ST_PARALLEL;
    end else if (s11_meta_q[MTW-1] && !in_all) begin
      st_d = lpi_pkg::ST_OUTSIDE;
    end else begin
      st_d = lpi_pkg::ST_HIT;
    end
  end

  assign en          = !out_v_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign status_o    = out_st_q;
  assign cross_x_o   = $signed(out_x_q);
  assign cross_y_o   = $signed(out_y_q);

  // valid bits of the top level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      s9_v_q  <= 1'b0;
      s10_v_q <= 1'b0;
      s11_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= ga_v && gb_v;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= xd_v;
      s8_v_q  <= s7_v_q;
      s9_v_q  <= s8_v_q;
      s10_v_q <= s9_v_q;
      s11_v_q <= s10_v_q;
      out_v_q <= s11_v_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      s1_meta_q <= {between_points_i, cin[7], cin[6], cin[5], cin[4],
                    cin[3], cin[2], cin[1], cin[0]};
      // stage 2
      s2_meta_q <= s1_meta_q;
      s2_vert_q <= (dxa == '0) || (dxb == '0);
      s2_nega_q <= dxa[C] ^ dya[C];
      s2_negb_q <= dxb[C] ^ dyb[C];
      s2_dxa_q  <= dxa_a[C-1:0];
      s2_dya_q  <= dya_a[C-1:0];
      s2_dxb_q  <= dxb_a[C-1:0];
      s2_dyb_q  <= dyb_a[C-1:0];
      // stage 3
      s3_vert_q <= ga_side[SWA-1];
      s3_meta_q <= ga_side[MTW-1:0];
      s3_ma_q   <= ga_side[MTW] ? -ma_u : ma_u;
      s3_mb_q   <= gb_side ? -mb_u : mb_u;
      // stage 4
      s4_vert_q <= s3_vert_q;
      s4_par_q  <= (s3_ma_q == s3_mb_q);
      s4_pa_q   <= PW'(crd(s3_meta_q, 0)) * PW'(s3_ma_q);
      s4_pb_q   <= PW'(crd(s3_meta_q, 4)) * PW'(s3_mb_q);
      s4_ma_q   <= s3_ma_q;
      s4_den_q  <= (MW+1)'(s3_ma_q) - (MW+1)'(s3_mb_q);
      s4_meta_q <= s3_meta_q;
      // stage 5
      s5_vert_q <= s4_vert_q;
      s5_par_q  <= s4_par_q;
      s5_ca_q   <= (CW'(crd(s4_meta_q, 1)) <<< F) - CW'(s4_pa_q);
      s5_cb_q   <= (CW'(crd(s4_meta_q, 5)) <<< F) - CW'(s4_pb_q);
      s5_ma_q   <= s4_ma_q;
      s5_den_q  <= s4_den_q;
      s5_meta_q <= s4_meta_q;
      // stage 6
      s6_vert_q <= s5_vert_q;
      s6_par_q  <= s5_par_q;
      s6_negx_q <= xnum[NWD-1] ^ s5_den_q[MW];
      s6_num_q  <= xnum_a;
      s6_den_q  <= xden_a[MW-1:0];
      s6_ca_q   <= s5_ca_q;
      s6_ma_q   <= s5_ma_q;
      s6_meta_q <= s5_meta_q;
      // stage 7
      s7_vert_q <= xd_side[SWX-1];
      s7_par_q  <= xd_side[SWX-2];
      s7_x_q    <= xd_side[SWX-3] ? -x_u : x_u;
      s7_ma_q   <= $signed(xd_side[MTW+CW +: MW]);
      s7_ca_q   <= $signed(xd_side[MTW +: CW]);
      s7_meta_q <= xd_side[MTW-1:0];
      // stage 8
      s8_vert_q <= s7_vert_q;
      s8_par_q  <= s7_par_q;
      s8_x_q    <= s7_x_q;
      if (s7_x_q > X_HI) begin
        s8_xc_q <= X_HI[63:0];
      end else if (s7_x_q < X_LO) begin
        s8_xc_q <= X_LO[63:0];
      end else begin
        s8_xc_q <= s7_x_q[63:0];
      end
      s8_ma_q   <= s7_ma_q;
      s8_ca_q   <= s7_ca_q;
      s8_meta_q <= s7_meta_q;
      // stage 9
      s9_vert_q <= s8_vert_q;
      s9_par_q  <= s8_par_q;
      s9_x_q    <= s8_x_q;
      s9_plo_q  <= LW'(s8_ma_q) * LW'($signed({1'b0, s8_xc_q[31:0]}));
      s9_phi_q  <= HW'(s8_ma_q) * HW'($signed(s8_xc_q[63:32]));
      s9_ca_q   <= s8_ca_q;
      s9_meta_q <= s8_meta_q;
      // stage 10
      s10_vert_q <= s9_vert_q;
      s10_par_q  <= s9_par_q;
      s10_x_q    <= s9_x_q;
      s10_ps_q   <= (YP'(s9_phi_q) <<< lpi_pkg::HALF_W) + YP'(s9_plo_q);
      s10_ca_q   <= s9_ca_q;
      s10_meta_q <= s9_meta_q;
      // stage 11
      s11_vert_q <= s10_vert_q;
      s11_par_q  <= s10_par_q;
      s11_x_q    <= s10_x_q;
      s11_y_q    <= YW'(s10_ps_q >>> F) + YW'(s10_ca_q);
      s11_meta_q <= s10_meta_q;
      // stage 12
      out_st_q      <= st_d;
      out_between_q <= s11_meta_q[MTW-1];
      out_x_q       <= (st_d == lpi_pkg::ST_HIT) ? sat_f(xf) : MISS;
      out_y_q       <= (st_d == lpi_pkg::ST_HIT) ? sat_f(yf) : MISS;
    end
  end

  // any miss reports -1.0 on both coordinates
  a_miss_coords : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != lpi_pkg::ST_HIT
    |-> out_x_q == MISS && out_y_q == MISS)
    else $error("miss item without -1.0 coordinates");

  // the segment status only appears when the check was asked for
  a_outside_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == lpi_pkg::ST_OUTSIDE |-> out_between_q)
    else $error("outside status without segment check");

  // a held output item keeps the pipe frozen behind it
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(s11_v_q) && $stable(s11_x_q))
    else $error("pipeline moved during output stall");

endmodule
`default_nettype wire
